// ----- rtl/core/owk_pkg.sv -----
// Package for the omni wheel kinematics PWM block: widths, register map,
// reset values and the configuration bundle shared by the core modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package owk_pkg;

  // Field widths
  localparam int VelW   = 16;   // signed Q7.8 velocity fields
  localparam int DutyW  = 16;   // PWM duty
  localparam int CfgW   = 24;   // widest configuration register
  localparam int IdxW   = 3;    // configuration register index

  // Datapath widths
  localparam int ProdW  = 33;   // d*wz and vx*sin60 in signed Q.24
  localparam int SumW   = 34;   // wheel sum in signed Q.24
  localparam int SpeedW = 50;   // wheel speed in signed Q.32
  localparam int MagW   = 49;   // speed magnitude
  localparam int TW     = 50;   // magnitude plus offset
  localparam int HalfW  = 25;   // split point of the duty multiply
  localparam int PartW  = 49;   // one partial product of the duty multiply
  localparam int QW     = 35;   // unsaturated duty

  // sin(60 deg) in unsigned Q0.16, rounded to nearest
  localparam logic [16:0] Sin60Q16 = 17'd56756;

  // Latency from accepted command to result strobe
  localparam int Latency = 8;

  // Configuration register map
  typedef enum logic [IdxW-1:0] {
    RegCenterDistance = 3'd0,
    RegInverseRadius  = 3'd1,
    RegSpeedOffset    = 3'd2,
    RegPwmPerSpeed    = 3'd3,
    RegPwmFullScale   = 3'd4
  } cfg_reg_e;

  // Reset values
  localparam logic [15:0] CenterDistanceRst = 16'd23593;
  localparam logic [15:0] InverseRadiusRst  = 16'd2560;
  localparam logic [15:0] SpeedOffsetRst    = 16'd0;
  localparam logic [23:0] PwmPerSpeedRst    = 24'd536981;
  localparam logic [15:0] PwmFullScaleRst   = 16'd65025;

  // Settings each wheel lane needs
  typedef struct packed {
    logic [15:0] inverse_radius;
    logic [15:0] speed_offset;
    logic [23:0] pwm_per_speed;
    logic [15:0] pwm_full_scale;
  } wheel_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/omni_wheel_kinematics_pwm.sv -----
// Top level of the omni wheel kinematics PWM block: configuration registers,
// shared velocity terms and three wheel lanes.
// Depends on owk_pkg and owk_wheel.
`timescale 1ns / 1ps
`default_nettype none

// A velocity command is taken whenever start is high; busy stays low, so one
// command can enter every cycle. Each command yields one result, shown for one
// cycle with done_o high, from the eight-stage pipeline (two stages of shared
// terms, six per wheel lane). Results cannot be held off, so capture them on
// the cycle done_o is high. Write configuration only while no command is in
// flight; writes to indexes beyond the register map are dropped.
module omni_wheel_kinematics_pwm (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [owk_pkg::VelW-1:0]      linear_x_i,
  input  wire logic signed [owk_pkg::VelW-1:0]      linear_y_i,
  input  wire logic signed [owk_pkg::VelW-1:0]      angular_z_i,
  // result channel
  output logic                                      done_o,
  output logic             [owk_pkg::DutyW-1:0]     duty_one_o,
  output logic             [owk_pkg::DutyW-1:0]     duty_two_o,
  output logic             [owk_pkg::DutyW-1:0]     duty_three_o,
  output logic                                      reverse_one_o,
  output logic                                      forward_two_o,
  output logic                                      reverse_three_o,
  // configuration channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic        [owk_pkg::IdxW-1:0]      cfg_index_i,
  input  wire logic        [owk_pkg::CfgW-1:0]      cfg_data_i
);

  // Configuration registers
  logic [15:0] center_distance_q;
  logic [15:0] inverse_radius_q;
  logic [15:0] speed_offset_q;
  logic [23:0] pwm_per_speed_q;
  logic [15:0] pwm_full_scale_q;

  logic accept;
  logic cfg_write;

  // Valid bits, one per pipeline stage
  logic [owk_pkg::Latency-1:0] valid_q;
  logic [owk_pkg::Latency-1:0] valid_d;

  // Stage 1: shared products
  logic signed [owk_pkg::ProdW-1:0] rot_q;
  logic signed [owk_pkg::ProdW-1:0] side_q;
  logic signed [owk_pkg::VelW-1:0]  vy_q;

  // Stage 2: wheel sums
  logic signed [owk_pkg::SumW-1:0] sum_one_q;
  logic signed [owk_pkg::SumW-1:0] sum_two_q;
  logic signed [owk_pkg::SumW-1:0] sum_three_q;

  logic signed [owk_pkg::SumW-1:0] rot_ext;
  logic signed [owk_pkg::SumW-1:0] side_ext;
  logic signed [owk_pkg::SumW-1:0] half_y;
  logic signed [owk_pkg::SumW-1:0] full_y;

  owk_pkg::wheel_cfg_t wheel_cfg;

  logic pos_one;
  logic pos_two;
  logic pos_three;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Hold the configuration; drop writes outside the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_distance_q <= owk_pkg::CenterDistanceRst;
      inverse_radius_q  <= owk_pkg::InverseRadiusRst;
      speed_offset_q    <= owk_pkg::SpeedOffsetRst;
      pwm_per_speed_q   <= owk_pkg::PwmPerSpeedRst;
      pwm_full_scale_q  <= owk_pkg::PwmFullScaleRst;
    end else if (cfg_write) begin
      case (cfg_index_i)
        owk_pkg::RegCenterDistance: center_distance_q <= cfg_data_i[15:0];
        owk_pkg::RegInverseRadius:  inverse_radius_q  <= cfg_data_i[15:0];
        owk_pkg::RegSpeedOffset:    speed_offset_q    <= cfg_data_i[15:0];
        owk_pkg::RegPwmPerSpeed:    pwm_per_speed_q   <= cfg_data_i;
        owk_pkg::RegPwmFullScale:   pwm_full_scale_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Advance the valid bits with the data
  assign valid_d = {valid_q[owk_pkg::Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1: rotation term and sideways term
  always_ff @(posedge clk_i) begin
    rot_q  <= $signed({1'b0, center_distance_q}) * angular_z_i;
    side_q <= linear_x_i * $signed(owk_pkg::Sin60Q16);
    vy_q   <= linear_y_i;
  end

  // Stage 2: combine into the three wheel sums, all in Q.24
  assign rot_ext  = owk_pkg::SumW'(rot_q);
  assign side_ext = owk_pkg::SumW'(side_q);
  assign half_y   = {{3{vy_q[owk_pkg::VelW-1]}}, vy_q, 15'b0};
  assign full_y   = {{2{vy_q[owk_pkg::VelW-1]}}, vy_q, 16'b0};

  always_ff @(posedge clk_i) begin
    sum_one_q   <= rot_ext - half_y + side_ext;
    sum_two_q   <= rot_ext - half_y - side_ext;
    sum_three_q <= rot_ext + full_y;
  end

  assign wheel_cfg.inverse_radius = inverse_radius_q;
  assign wheel_cfg.speed_offset   = speed_offset_q;
  assign wheel_cfg.pwm_per_speed  = pwm_per_speed_q;
  assign wheel_cfg.pwm_full_scale = pwm_full_scale_q;

  owk_wheel u_wheel_one (
    .clk_i      (clk_i),
    .cfg_i      (wheel_cfg),
    .sum_i      (sum_one_q),
    .duty_o     (duty_one_o),
    .positive_o (pos_one)
  );

  owk_wheel u_wheel_two (
    .clk_i      (clk_i),
    .cfg_i      (wheel_cfg),
    .sum_i      (sum_two_q),
    .duty_o     (duty_two_o),
    .positive_o (pos_two)
  );

  owk_wheel u_wheel_three (
    .clk_i      (clk_i),
    .cfg_i      (wheel_cfg),
    .sum_i      (sum_three_q),
    .duty_o     (duty_three_o),
    .positive_o (pos_three)
  );

  // Direction bits with each wheel's polarity
  assign reverse_one_o   = !pos_one;
  assign forward_two_o   = pos_two;
  assign reverse_three_o = !pos_three;

  assign done_o = valid_q[owk_pkg::Latency-1];

endmodule

`default_nettype wire

// ----- rtl/core/owk_wheel.sv -----
// One wheel lane: scales the wheel sum by 1/r, then maps the magnitude to a
// saturated PWM duty and a sign flag. Six register stages.
// Depends on owk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owk_wheel (
  input  wire logic                               clk_i,
  input  wire owk_pkg::wheel_cfg_t                cfg_i,
  input  wire logic signed [owk_pkg::SumW-1:0]    sum_i,
  output logic             [owk_pkg::DutyW-1:0]   duty_o,
  output logic                                    positive_o
);

  // Stage 1: wheel speed
  logic signed [owk_pkg::SpeedW-1:0] speed_q;

  // Stage 2: magnitude and flags
  logic [owk_pkg::MagW-1:0] mag_q;
  logic                     nz_q [2:5];
  logic                     pos_q [2:5];

  // Stage 3: magnitude plus offset
  logic [owk_pkg::TW-1:0] t_q;

  // Stage 4: partial products
  logic [owk_pkg::PartW-1:0] ph_q;
  logic [owk_pkg::PartW-1:0] pl_q;

  // Stage 5: unsaturated duty
  logic [owk_pkg::QW-1:0] q_q;

  // Stage 6: output register
  logic [owk_pkg::DutyW-1:0] duty_q;
  logic                      pos_out_q;

  logic signed [owk_pkg::SpeedW-1:0] neg_speed;
  logic [owk_pkg::PartW:0]           hi_sum;

  assign neg_speed = -speed_q;
  assign hi_sum    = (owk_pkg::PartW+1)'(ph_q)
                   + (owk_pkg::PartW+1)'(pl_q[owk_pkg::PartW-1:owk_pkg::HalfW]);

  // Datapath registers run freely; the top level tracks validity
  always_ff @(posedge clk_i) begin
    // scale by 1/r (Q8.8)
    speed_q <= sum_i * $signed({1'b0, cfg_i.inverse_radius});

    // take the magnitude and the sign
    mag_q    <= speed_q[owk_pkg::SpeedW-1] ? neg_speed[owk_pkg::MagW-1:0]
                                           : speed_q[owk_pkg::MagW-1:0];
    nz_q[2]  <= (speed_q != '0);
    pos_q[2] <= !speed_q[owk_pkg::SpeedW-1] && (speed_q != '0);

    // add the offset, aligned to Q.32
    t_q      <= owk_pkg::TW'(mag_q) + {10'b0, cfg_i.speed_offset, 24'b0};
    nz_q[3]  <= nz_q[2];
    pos_q[3] <= pos_q[2];

    // split the gain multiply into two halves
    ph_q     <= t_q[owk_pkg::TW-1:owk_pkg::HalfW] * cfg_i.pwm_per_speed;
    pl_q     <= t_q[owk_pkg::HalfW-1:0] * cfg_i.pwm_per_speed;
    nz_q[4]  <= nz_q[3];
    pos_q[4] <= pos_q[3];

    // merge the halves and drop 40 fraction bits
    q_q      <= hi_sum[owk_pkg::PartW:15];
    nz_q[5]  <= nz_q[4];
    pos_q[5] <= pos_q[4];

    // saturate; a zero speed gives zero duty
    if (!nz_q[5]) begin
      duty_q <= '0;
    end else if (q_q > owk_pkg::QW'(cfg_i.pwm_full_scale)) begin
      duty_q <= cfg_i.pwm_full_scale;
    end else begin
      duty_q <= q_q[owk_pkg::DutyW-1:0];
    end
    pos_out_q <= pos_q[5];
  end

  assign duty_o     = duty_q;
  assign positive_o = pos_out_q;

endmodule

`default_nettype wire

// ----- rtl/core/owk_checker.sv -----
// Port-level checks for the omni wheel kinematics PWM block, bound to the
// top level. Depends on owk_pkg and omni_wheel_kinematics_pwm.
`timescale 1ns / 1ps
`default_nettype none

module owk_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic signed [owk_pkg::VelW-1:0]      linear_x_i,
  input wire logic signed [owk_pkg::VelW-1:0]      linear_y_i,
  input wire logic signed [owk_pkg::VelW-1:0]      angular_z_i,
  input wire logic                                 done_o,
  input wire logic        [owk_pkg::DutyW-1:0]     duty_one_o,
  input wire logic        [owk_pkg::DutyW-1:0]     duty_two_o,
  input wire logic        [owk_pkg::DutyW-1:0]     duty_three_o,
  input wire logic                                 reverse_one_o,
  input wire logic                                 forward_two_o,
  input wire logic                                 reverse_three_o
);

  // Every accepted transaction yields a result after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##8 done_o)
    else $error("accepted command produced no result");

  // No result without a transaction accepted at the fixed latency before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 8))
    else $error("result without a matching command");

  // A zero command stops every wheel with the zero speed polarities
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && linear_x_i == '0 && linear_y_i == '0
                     && angular_z_i == '0, 8))
    |-> (duty_one_o == '0 && duty_two_o == '0 && duty_three_o == '0
         && reverse_one_o && !forward_two_o && reverse_three_o))
    else $error("zero command gave a nonzero result");

  // With no forward velocity, wheels one and two turn alike
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && linear_x_i == '0, 8))
    |-> (duty_one_o == duty_two_o && reverse_one_o == !forward_two_o))
    else $error("wheels one and two disagree with no forward velocity");

endmodule

bind omni_wheel_kinematics_pwm owk_checker u_owk_checker (.*);

`default_nettype wire
